### src/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and stage counts for the vector normalization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

  // Bits of the input components and of the magnitude.
  localparam int CompW     = 32;
  // Radicand width: the sum of three squares of 32-bit magnitudes.
  localparam int SumW      = 2 * CompW;
  // Width of a Q1.15 unit component.
  localparam int UnitW     = 16;
  // Fraction bits of the Q1.15 format.
  localparam int FracW     = UnitW - 1;
  // Dividend width: magnitude of a component shifted by the fraction.
  localparam int DivW      = CompW + FracW + 1;
  // One root bit per square root stage.
  localparam int SqrtStages = CompW;
  // One quotient bit per divide stage.
  localparam int DivStages  = UnitW;
  localparam int NumComp    = 3;

  localparam logic [UnitW-1:0] UnitMaxPos = {1'b0, {(UnitW-1){1'b1}}};

  // Sign and magnitude of one component.
  typedef struct packed {
    logic             neg;
    logic [CompW-1:0] abs_val;
  } comp_t;

  // Sum of squares with the components that produced it.
  typedef struct packed {
    logic [SumW-1:0]          sum;
    comp_t [NumComp-1:0]      comp;
  } sum_bus_t;

  // Magnitude with the components still to be divided.
  typedef struct packed {
    logic [CompW-1:0]         mag;
    comp_t [NumComp-1:0]      comp;
  } mag_bus_t;

  // Finished result item.
  typedef struct packed {
    logic [CompW-1:0]              magnitude;
    logic [NumComp-1:0][UnitW-1:0] unit;
    logic                          zero_vector;
  } res_t;

endpackage

`default_nettype wire

### src/vn_if.sv
// ----------------------------------------------------------------------------
// vn_in_if / vn_out_if
// Valid/ready channels that carry input vectors and normalized results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_component;
  logic signed [31:0] y_component;
  logic signed [31:0] z_component;

  modport source (output valid, x_component, y_component, z_component, input ready);
  modport sink   (input valid, x_component, y_component, z_component, output ready);
endinterface

interface vn_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] magnitude;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               zero_vector;

  modport source (output valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                  input ready);
  modport sink   (input valid, magnitude, unit_x, unit_y, unit_z, zero_vector,
                  output ready);
endinterface

`default_nettype wire

### src/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square
// Absolute values, squares and sum of squares in four elastic stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_square (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [31:0]     x_i,
  input  wire logic signed [31:0]     y_i,
  input  wire logic signed [31:0]     z_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output vn_pkg::sum_bus_t            out_o
);
  import vn_pkg::*;

  logic [3:0] v_q;
  logic [4:0] rdy;

  comp_t [NumComp-1:0]  c0_q, c1_q, c2_q, c3_q;
  comp_t [NumComp-1:0]  c0_d;
  logic  [NumComp-1:0][SumW-1:0] sq1_q;
  logic  [SumW-1:0]     part2_q, zz2_q, sum3_q;
  logic  [NumComp-1:0][CompW-1:0] raw;

  assign raw = {z_i, y_i, x_i};

  // A stage takes new data when it is empty or its successor moves.
  assign rdy[4] = out_ready_i;
  always_comb begin
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      c0_d[i].neg     = raw[i][CompW-1];
      c0_d[i].abs_val = raw[i][CompW-1] ? CompW'(-raw[i]) : raw[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) c0_q <= c0_d;
    if (rdy[1]) begin
      c1_q <= c0_q;
      for (int i = 0; i < NumComp; i++) begin
        sq1_q[i] <= SumW'(c0_q[i].abs_val) * SumW'(c0_q[i].abs_val);
      end
    end
    if (rdy[2]) begin
      c2_q    <= c1_q;
      part2_q <= sq1_q[0] + sq1_q[1];
      zz2_q   <= sq1_q[2];
    end
    if (rdy[3]) begin
      c3_q   <= c2_q;
      sum3_q <= part2_q + zz2_q;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o.sum   = sum3_q;
  assign out_o.comp  = c3_q;

endmodule

`default_nettype wire

### src/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Restoring integer square root, one root bit per elastic stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sqrt (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire vn_pkg::sum_bus_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output vn_pkg::mag_bus_t      out_o
);
  import vn_pkg::*;

  typedef struct packed {
    logic [SumW-1:0]     rem;
    logic [CompW-1:0]    root;
    comp_t [NumComp-1:0] comp;
  } sq_stage_t;

  sq_stage_t             st_q [SqrtStages];
  sq_stage_t             prev [SqrtStages];
  logic [SqrtStages-1:0] pv;
  logic [SqrtStages-1:0] v_q;
  logic [SqrtStages:0]   rdy;

  assign prev[0] = '{rem: in_i.sum, root: '0, comp: in_i.comp};
  assign pv[0]   = in_valid_i;
  assign rdy[SqrtStages] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    localparam int B = SqrtStages - 1 - s;
    logic [SumW:0] trial;
    logic          take;

    if (s > 0) begin : g_link
      assign prev[s] = st_q[s-1];
      assign pv[s]   = v_q[s-1];
    end

    // Adding bit B to the root grows its square by root*2^(B+1) + 2^(2B).
    assign trial = ((SumW+1)'(prev[s].root) << (B + 1)) | ((SumW+1)'(1) << (2 * B));
    assign take  = {1'b0, prev[s].rem} >= trial;
    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= pv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        st_q[s].comp <= prev[s].comp;
        st_q[s].rem  <= take ? SumW'({1'b0, prev[s].rem} - trial) : prev[s].rem;
        st_q[s].root <= prev[s].root | (CompW'(take) << B);
      end
    end
  end

  assign out_valid_o = v_q[SqrtStages-1];
  assign out_o.mag   = st_q[SqrtStages-1].root;
  assign out_o.comp  = st_q[SqrtStages-1].comp;

endmodule

`default_nettype wire

### src/vn_divide.sv
// ----------------------------------------------------------------------------
// vn_divide
// Restoring division of each component by the magnitude, one quotient bit
// per elastic stage, followed by a saturating output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_divide (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire vn_pkg::mag_bus_t in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output vn_pkg::res_t          out_o
);
  import vn_pkg::*;

  typedef struct packed {
    logic [NumComp-1:0][DivW-1:0]  rem;
    logic [NumComp-1:0][UnitW-1:0] quo;
    logic [CompW-1:0]              mag;
    logic [NumComp-1:0]            neg;
  } dv_stage_t;

  dv_stage_t            st_q [DivStages];
  dv_stage_t            prev [DivStages];
  logic [DivStages-1:0] pv;
  logic [DivStages-1:0] v_q;
  logic [DivStages:0]   rdy;
  logic                 res_v_q;
  res_t                 res_q, res_d;

  always_comb begin
    prev[0].mag = in_i.mag;
    for (int i = 0; i < NumComp; i++) begin
      prev[0].rem[i] = {1'b0, in_i.comp[i].abs_val, {FracW{1'b0}}};
      prev[0].quo[i] = '0;
      prev[0].neg[i] = in_i.comp[i].neg;
    end
  end
  assign pv[0] = in_valid_i;
  assign rdy[DivStages] = !res_v_q || out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int B = DivStages - 1 - s;
    logic [DivW-1:0]    dvs;
    logic [NumComp-1:0] take;

    if (s > 0) begin : g_link
      assign prev[s] = st_q[s-1];
      assign pv[s]   = v_q[s-1];
    end

    assign dvs    = DivW'(prev[s].mag) << B;
    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_comb begin
      for (int i = 0; i < NumComp; i++) begin
        take[i] = prev[s].rem[i] >= dvs;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= pv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        st_q[s].mag <= prev[s].mag;
        st_q[s].neg <= prev[s].neg;
        for (int i = 0; i < NumComp; i++) begin
          st_q[s].rem[i] <= take[i] ? prev[s].rem[i] - dvs : prev[s].rem[i];
          st_q[s].quo[i] <= prev[s].quo[i] | (UnitW'(take[i]) << B);
        end
      end
    end
  end

  // The quotient never exceeds 1.0, so only the positive side can overflow.
  always_comb begin
    res_d.magnitude   = st_q[DivStages-1].mag;
    res_d.zero_vector = st_q[DivStages-1].mag == '0;
    for (int i = 0; i < NumComp; i++) begin
      if (res_d.zero_vector) begin
        res_d.unit[i] = '0;
      end else if (st_q[DivStages-1].neg[i]) begin
        res_d.unit[i] = UnitW'(-st_q[DivStages-1].quo[i]);
      end else if (st_q[DivStages-1].quo[i][UnitW-1]) begin
        res_d.unit[i] = UnitMaxPos;
      end else begin
        res_d.unit[i] = st_q[DivStages-1].quo[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (rdy[DivStages]) begin
      res_v_q <= v_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DivStages]) res_q <= res_d;
  end

  assign out_valid_o = res_v_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

### src/vector3_normalize.sv
// ----------------------------------------------------------------------------
// vector3_normalize
// Euclidean magnitude (Q16.16) and unit vector (Q1.15) of a Q16.16 vector.
// ----------------------------------------------------------------------------
//
//   Port     Direction  Payload
//   in_if    sink       x_component, y_component, z_component (signed Q16.16)
//   out_if   source     magnitude (Q16.16), unit_x/y/z (Q1.15), zero_vector
//
// One item enters per clock while out_if accepts results; an item passes four
// square-and-sum stages, 32 square root stages (one root bit each), 16 divide
// stages (one quotient bit each) and the output register.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so a stall on out_if fills gaps before it blocks in_if.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vn_in_if.sink     in_if,
  vn_out_if.source  out_if
);
  import vn_pkg::*;

  logic     sq_valid, sq_ready;
  sum_bus_t sq_bus;
  logic     rt_valid, rt_ready;
  mag_bus_t rt_bus;
  res_t     res;

  // Absolute values, squares and their sum.
  vn_square u_square (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .x_i         (in_if.x_component),
    .y_i         (in_if.y_component),
    .z_i         (in_if.z_component),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_o       (sq_bus)
  );

  // Truncated square root of the Q32.32 sum gives the Q16.16 magnitude.
  vn_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .in_i        (sq_bus),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_o       (rt_bus)
  );

  // Each component over the magnitude, then sign and saturation.
  vn_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_i        (rt_bus),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_o       (res)
  );

  assign out_if.magnitude   = res.magnitude;
  assign out_if.unit_x      = res.unit[0];
  assign out_if.unit_y      = res.unit[1];
  assign out_if.unit_z      = res.unit[2];
  assign out_if.zero_vector = res.zero_vector;

  // A zero flag comes with a zero magnitude and a zero unit vector.
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.zero_vector |->
      out_if.magnitude == '0 && out_if.unit_x == '0 &&
      out_if.unit_y == '0 && out_if.unit_z == '0)
    else $error("zero vector result carries nonzero fields");

  // Without the zero flag the magnitude is never zero.
  a_nonzero_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.zero_vector |-> out_if.magnitude != '0)
    else $error("nonzero result with zero magnitude");

  // No result leaves in the cycle after reset is held.
  a_reset_empty : assert property (@(posedge clk_i)
    !rst_ni |=> !out_if.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
